// File: hdl/fbrs_pkg.sv
// fbrs_pkg: shared types and constants of the framebuffer rectangle scroll unit.
// Coordinate and clip types, command and register codes, result record.
// No dependencies.
package fbrs_pkg;

   localparam int CW         = 12;
   localparam int DIM_W      = 10;
   localparam int OUT_PIXEL_W = 32;

   typedef logic signed [CW-1:0] coord_type;
   typedef logic [DIM_W-1:0]     dim_type;

   localparam logic [1:0] CMD_WRITE  = 2'd0;
   localparam logic [1:0] CMD_READ   = 2'd1;
   localparam logic [1:0] CMD_SCROLL = 2'd2;

   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   typedef struct packed {
      coord_type x0;
      coord_type x1;
      coord_type y0;
      coord_type y1;
   } clip_type;

   typedef struct packed {
      logic [OUT_PIXEL_W-1:0] pixel;
      logic                   ok;
      logic                   moved;
   } result_type;

endpackage

// File: hdl/fbrs_store.sv
// fbrs_store: frame store memory, one write port and one read port.
// Read data is registered; read-first on a same-address collision.
// No dependencies.
module fbrs_store #(
   parameter int DEPTH = 65536,
   parameter int AW    = 16,
   parameter int DW    = 32
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] frame_mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= frame_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/fbrs_clip.sv
// fbrs_clip: clips a scroll rectangle against the image and the shifted image.
// Combinational; uses fbrs_pkg.
module fbrs_clip (
   input  logic signed [9:0]  pos_x,
   input  logic signed [9:0]  pos_y,
   input  logic [9:0]         rect_width,
   input  logic [9:0]         rect_height,
   input  logic signed [9:0]  shift_x,
   input  logic signed [9:0]  shift_y,
   input  fbrs_pkg::dim_type  img_w,
   input  fbrs_pkg::dim_type  img_h,
   output fbrs_pkg::clip_type clip
);

   function automatic fbrs_pkg::coord_type smax(fbrs_pkg::coord_type a, fbrs_pkg::coord_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic fbrs_pkg::coord_type smin(fbrs_pkg::coord_type a, fbrs_pkg::coord_type b);
      return (a < b) ? a : b;
   endfunction

   fbrs_pkg::coord_type px, py, rw, rh, ox, oy, w, h;

   always_comb begin
      px = fbrs_pkg::CW'(pos_x);
      py = fbrs_pkg::CW'(pos_y);
      ox = fbrs_pkg::CW'(shift_x);
      oy = fbrs_pkg::CW'(shift_y);
      rw = $signed({2'b00, rect_width});
      rh = $signed({2'b00, rect_height});
      w  = $signed({2'b00, img_w});
      h  = $signed({2'b00, img_h});
      clip.x0 = smax(px, smax('0, -ox));
      clip.x1 = smin(px + rw, smin(w, w - ox));
      clip.y0 = smax(py, smax('0, -oy));
      clip.y1 = smin(py + rh, smin(h, h - oy));
   end

endmodule

// File: hdl/fbrs_seq.sv
// fbrs_seq: command sequencer: pixel access, scroll scan with read/write-back, result register.
// Drives the fbrs_store ports; takes the clip from fbrs_clip; uses fbrs_pkg.
module fbrs_seq #(
   parameter int MAX_WIDTH  = 256,
   parameter int PIXEL_BITS = 32,
   parameter int AW         = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_cmd,
   input  logic signed [9:0]     req_pos_x,
   input  logic signed [9:0]     req_pos_y,
   input  logic signed [9:0]     req_shift_x,
   input  logic signed [9:0]     req_shift_y,
   input  logic [31:0]           req_pixel_in,
   input  fbrs_pkg::clip_type    clip,
   input  fbrs_pkg::dim_type     img_w,
   input  fbrs_pkg::dim_type     img_h,
   output logic                  mem_wr_en,
   output logic [AW-1:0]         mem_wr_addr,
   output logic [PIXEL_BITS-1:0] mem_wr_data,
   output logic                  mem_rd_en,
   output logic [AW-1:0]         mem_rd_addr,
   input  logic [PIXEL_BITS-1:0] mem_rd_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [31:0]           rsp_pixel_out,
   output logic                  rsp_ok,
   output logic                  rsp_moved
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_READ  = 6'b000010,
      ST_SETUP = 6'b000100,
      ST_SCAN  = 6'b001000,
      ST_DRAIN = 6'b010000,
      ST_FIN   = 6'b100000
   } state_type;

   function automatic logic [AW-1:0] addr_of(fbrs_pkg::coord_type x, fbrs_pkg::coord_type y);
      return AW'($unsigned(y)) * AW'(MAX_WIDTH) + AW'($unsigned(x));
   endfunction

   state_type            state_ff, state_in;
   fbrs_pkg::result_type res_ff, res_in;
   fbrs_pkg::result_type rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   fbrs_pkg::clip_type   clip_ff, clip_in;
   fbrs_pkg::coord_type  ox_ff, ox_in, oy_ff, oy_in;
   fbrs_pkg::coord_type  cx_ff, cx_in, cy_ff, cy_in;
   fbrs_pkg::coord_type  x_first_ff, x_first_in, x_last_ff, x_last_in, y_last_ff, y_last_in;
   logic                 rev_x_ff, rev_x_in, down_ff, down_in;
   logic                 wr_pend_ff, wr_pend_in;
   logic [AW-1:0]        wr_addr_ff, wr_addr_in;
   fbrs_pkg::coord_type  px, py, w, h;
   logic                 img_ok, pix_hit, out_free;

   always_comb begin
      px       = fbrs_pkg::CW'(req_pos_x);
      py       = fbrs_pkg::CW'(req_pos_y);
      w        = $signed({2'b00, img_w});
      h        = $signed({2'b00, img_h});
      img_ok   = (img_w != '0) && (img_h != '0);
      pix_hit  = img_ok && (px >= 0) && (px < w) && (py >= 0) && (py < h);
      out_free = !rsp_valid_ff || rsp_ready;

      state_in   = state_ff;
      res_in     = res_ff;
      clip_in    = clip_ff;
      ox_in      = ox_ff;
      oy_in      = oy_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      x_first_in = x_first_ff;
      x_last_in  = x_last_ff;
      y_last_in  = y_last_ff;
      rev_x_in   = rev_x_ff;
      down_in    = down_ff;
      wr_pend_in = 1'b0;
      wr_addr_in = wr_addr_ff;
      req_ready  = (state_ff == ST_IDLE);

      mem_wr_en   = wr_pend_ff;
      mem_wr_addr = wr_addr_ff;
      mem_wr_data = mem_rd_data;
      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               res_in = '0;
               case (req_cmd)
                  fbrs_pkg::CMD_WRITE: begin
                     res_in.ok   = pix_hit;
                     mem_wr_en   = pix_hit;
                     mem_wr_addr = addr_of(px, py);
                     mem_wr_data = req_pixel_in[PIXEL_BITS-1:0];
                     state_in    = ST_FIN;
                  end
                  fbrs_pkg::CMD_READ: begin
                     res_in.ok   = pix_hit;
                     mem_rd_en   = pix_hit;
                     mem_rd_addr = addr_of(px, py);
                     state_in    = pix_hit ? ST_READ : ST_FIN;
                  end
                  fbrs_pkg::CMD_SCROLL: begin
                     res_in.ok = img_ok;
                     clip_in   = clip;
                     ox_in     = fbrs_pkg::CW'(req_shift_x);
                     oy_in     = fbrs_pkg::CW'(req_shift_y);
                     state_in  = img_ok ? ST_SETUP : ST_FIN;
                  end
                  default: begin
                     state_in = ST_FIN;
                  end
               endcase
            end
         end
         ST_READ: begin
            res_in.pixel = fbrs_pkg::OUT_PIXEL_W'(mem_rd_data);
            state_in     = ST_FIN;
         end
         ST_SETUP: begin
            rev_x_in   = (oy_ff == 0) && (ox_ff > 0);
            down_in    = (oy_ff > 0);
            x_first_in = rev_x_in ? fbrs_pkg::CW'(clip_ff.x1 - 1) : clip_ff.x0;
            x_last_in  = rev_x_in ? clip_ff.x0 : fbrs_pkg::CW'(clip_ff.x1 - 1);
            cx_in      = x_first_in;
            cy_in      = down_in ? fbrs_pkg::CW'(clip_ff.y1 - 1) : clip_ff.y0;
            y_last_in  = down_in ? clip_ff.y0 : fbrs_pkg::CW'(clip_ff.y1 - 1);
            if ((clip_ff.x0 < clip_ff.x1) && (clip_ff.y0 < clip_ff.y1)) begin
               res_in.moved = 1'b1;
               state_in     = ST_SCAN;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_SCAN: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = addr_of(cx_ff, cy_ff);
            wr_pend_in  = 1'b1;
            wr_addr_in  = addr_of(cx_ff + ox_ff, cy_ff + oy_ff);
            if (cx_ff == x_last_ff) begin
               cx_in = x_first_ff;
               if (cy_ff == y_last_ff) begin
                  state_in = ST_DRAIN;
               end else begin
                  cy_in = down_ff ? fbrs_pkg::CW'(cy_ff - 1) : fbrs_pkg::CW'(cy_ff + 1);
               end
            end else begin
               cx_in = rev_x_ff ? fbrs_pkg::CW'(cx_ff - 1) : fbrs_pkg::CW'(cx_ff + 1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if ((state_ff == ST_FIN) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         wr_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         wr_pend_ff   <= wr_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
      clip_ff    <= clip_in;
      ox_ff      <= ox_in;
      oy_ff      <= oy_in;
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      x_first_ff <= x_first_in;
      x_last_ff  <= x_last_in;
      y_last_ff  <= y_last_in;
      rev_x_ff   <= rev_x_in;
      down_ff    <= down_in;
      wr_addr_ff <= wr_addr_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_ff.pixel;
   assign rsp_ok        = rsp_ff.ok;
   assign rsp_moved     = rsp_ff.moved;

endmodule

// File: hdl/framebuffer_rect_scroll_unit.sv
// framebuffer_rect_scroll_unit: top level of the frame store with pixel access and scroll.
// Holds the image size registers; instantiates fbrs_clip, fbrs_store and fbrs_seq; uses fbrs_pkg.
//
//   channel | ports  | direction | transaction
//   --------+--------+-----------+-------------------------------------------
//   request | req_*  | in        | write pixel, read pixel or scroll rectangle
//   result  | rsp_*  | out       | pixel_out, ok, moved; one per request
//   csr     | csr_*  | in        | image_width, image_height; no handshake
//
// A scroll moves one pixel per cycle, as the store has a single read and a single write
// port; a read outside the image skips the store, as does a scroll with an empty clip.
// A request is taken while the previous result waits in the output register; a stalled
// result holds the sequencer in its final state. Reset clears the size registers and
// control state; store contents are undefined until written.
module framebuffer_rect_scroll_unit #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int PIXEL_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_cmd,
   input  logic signed [9:0] req_pos_x,
   input  logic signed [9:0] req_pos_y,
   input  logic [9:0]        req_rect_width,
   input  logic [9:0]        req_rect_height,
   input  logic signed [9:0] req_shift_x,
   input  logic signed [9:0] req_shift_y,
   input  logic [31:0]       req_pixel_in,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [31:0]       rsp_pixel_out,
   output logic              rsp_ok,
   output logic              rsp_moved,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [8:0]        csr_wdata
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [8:0]            image_width_ff, image_width_in;
   logic [8:0]            image_height_ff, image_height_in;
   fbrs_pkg::dim_type     img_w, img_h;
   fbrs_pkg::clip_type    clip;
   logic                  mem_wr_en, mem_rd_en;
   logic [AW-1:0]         mem_wr_addr, mem_rd_addr;
   logic [PIXEL_BITS-1:0] mem_wr_data, mem_rd_data;

   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      if (csr_we) begin
         case (csr_index)
            fbrs_pkg::CSR_IMAGE_WIDTH:  image_width_in  = csr_wdata;
            fbrs_pkg::CSR_IMAGE_HEIGHT: image_height_in = csr_wdata;
            default: ;
         endcase
      end
      img_w = (32'(image_width_ff) > MAX_WIDTH) ? fbrs_pkg::DIM_W'(MAX_WIDTH)
                                                : {1'b0, image_width_ff};
      img_h = (32'(image_height_ff) > MAX_HEIGHT) ? fbrs_pkg::DIM_W'(MAX_HEIGHT)
                                                  : {1'b0, image_height_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= '0;
         image_height_ff <= '0;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
      end
   end

   fbrs_clip u_clip (
      .pos_x       (req_pos_x),
      .pos_y       (req_pos_y),
      .rect_width  (req_rect_width),
      .rect_height (req_rect_height),
      .shift_x     (req_shift_x),
      .shift_y     (req_shift_y),
      .img_w       (img_w),
      .img_h       (img_h),
      .clip        (clip)
   );

   fbrs_store #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .DW    (PIXEL_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   fbrs_seq #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS),
      .AW         (AW)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_shift_x   (req_shift_x),
      .req_shift_y   (req_shift_y),
      .req_pixel_in  (req_pixel_in),
      .clip          (clip),
      .img_w         (img_w),
      .img_h         (img_h),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_data   (mem_wr_data),
      .mem_rd_en     (mem_rd_en),
      .mem_rd_addr   (mem_rd_addr),
      .mem_rd_data   (mem_rd_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_ok        (rsp_ok),
      .rsp_moved     (rsp_moved)
   );

   a_no_copy_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en && (mem_wr_addr == mem_rd_addr)))
      else $error("scroll write hits the address being read");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while previous transaction still in work");

   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result raised without a transaction in work");

endmodule
